### rtl/lrc_frame_builder_top_macros.svh
// assertion macros used by the frame builder queue rtl
// depends on i_clk and i_rst_n being present in the including module
`ifndef LRC_FRAME_BUILDER_TOP_MACROS_SVH
`define LRC_FRAME_BUILDER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define LRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lrc_fb_pkg.sv
// types, codes and constants for the frame builder
// no dependencies
package lrc_fb_pkg;

    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;
    localparam int CMD_BYTES = 9;
    localparam int IDX_W     = $clog2(CMD_BYTES);
    localparam int Q_AW      = 2;
    localparam int Q_DEPTH   = 1 << Q_AW;

    // input action codes
    localparam logic [1:0] ACT_OPEN  = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_CLOSE = 2'd2;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_START_WORD   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_VEHICLE_ID   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_CHECK_EN     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_DEFAULT_CHK  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_PLAIN_TYPE   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_END_BYTE     = 3'd5;

    localparam logic [15:0] FRAME_OVERHEAD = 16'd8;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] payload_length;
        logic [7:0]  seq_num;
        logic [7:0]  data_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
        logic       length_mismatch;
    } t_out_word;

    typedef enum logic [1:0] {
        CMD_OPEN,
        CMD_DATA,
        CMD_CLOSE
    } t_cmd_kind;

    // byte k of a command goes out k-th
    typedef struct packed {
        t_cmd_kind                      kind;
        logic                           mismatch;
        logic [CMD_BYTES-1:0][7:0]      bytes;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_push;

endpackage

### rtl/lrc_fb_front.sv
// front end: config registers, frame state, turns input words into commands
// depends on lrc_fb_pkg
module lrc_fb_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  lrc_fb_pkg::t_in_word              i_in_data,
    input  logic                              i_cfg_valid,
    input  logic [lrc_fb_pkg::CFG_AW-1:0]     i_cfg_index,
    input  logic [lrc_fb_pkg::CFG_DW-1:0]     i_cfg_data,
    input  logic                              i_q_full,
    output lrc_fb_pkg::t_q_push               o_push
);
    import lrc_fb_pkg::*;

    logic [15:0] r_start_word;
    logic [31:0] r_vehicle_id;
    logic        r_check_en;
    logic [7:0]  r_default_chk;
    logic [7:0]  r_plain_type;
    logic [7:0]  r_end_byte;

    logic [7:0]  r_check_accum, n_check_accum;
    logic [15:0] r_payload_count, n_payload_count;
    logic [15:0] r_declared_length, n_declared_length;
    logic        r_frame_open, n_frame_open;

    logic        accept;
    logic [15:0] flen;
    logic [7:0]  acc_close;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign flen       = i_in_data.payload_length + FRAME_OVERHEAD;
    assign acc_close  = r_check_accum ^ r_plain_type;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_word  <= '0;
            r_vehicle_id  <= '0;
            r_check_en    <= 1'b0;
            r_default_chk <= '0;
            r_plain_type  <= '0;
            r_end_byte    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START_WORD:  r_start_word  <= i_cfg_data[15:0];
                REG_VEHICLE_ID:  r_vehicle_id  <= i_cfg_data[31:0];
                REG_CHECK_EN:    r_check_en    <= i_cfg_data[0];
                REG_DEFAULT_CHK: r_default_chk <= i_cfg_data[7:0];
                REG_PLAIN_TYPE:  r_plain_type  <= i_cfg_data[7:0];
                REG_END_BYTE:    r_end_byte    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_check_accum     = r_check_accum;
        n_payload_count   = r_payload_count;
        n_declared_length = r_declared_length;
        n_frame_open      = r_frame_open;
        o_push            = '0;
        if (accept) begin
            priority if (i_in_data.action == ACT_OPEN) begin
                o_push.valid          = 1'b1;
                o_push.cmd.kind       = CMD_OPEN;
                o_push.cmd.bytes[0]   = r_start_word[15:8];
                o_push.cmd.bytes[1]   = r_start_word[7:0];
                o_push.cmd.bytes[2]   = flen[7:0];
                o_push.cmd.bytes[3]   = flen[15:8];
                o_push.cmd.bytes[4]   = r_vehicle_id[7:0];
                o_push.cmd.bytes[5]   = r_vehicle_id[15:8];
                o_push.cmd.bytes[6]   = r_vehicle_id[23:16];
                o_push.cmd.bytes[7]   = r_vehicle_id[31:24];
                o_push.cmd.bytes[8]   = i_in_data.seq_num;
                n_check_accum     = r_vehicle_id[7:0] ^ r_vehicle_id[15:8]
                                  ^ r_vehicle_id[23:16] ^ r_vehicle_id[31:24]
                                  ^ i_in_data.seq_num;
                n_payload_count   = '0;
                n_declared_length = i_in_data.payload_length;
                n_frame_open      = 1'b1;
            end else if (i_in_data.action == ACT_DATA && r_frame_open) begin
                o_push.valid        = 1'b1;
                o_push.cmd.kind     = CMD_DATA;
                o_push.cmd.bytes[0] = i_in_data.data_byte;
                n_check_accum       = r_check_accum ^ i_in_data.data_byte;
                // count saturates at all ones
                if (r_payload_count != 16'hFFFF) begin
                    n_payload_count = r_payload_count + 16'd1;
                end
            end else if (i_in_data.action == ACT_CLOSE && r_frame_open) begin
                o_push.valid        = 1'b1;
                o_push.cmd.kind     = CMD_CLOSE;
                o_push.cmd.mismatch = (r_payload_count != r_declared_length);
                o_push.cmd.bytes[0] = r_plain_type;
                o_push.cmd.bytes[1] = r_check_en ? acc_close : r_default_chk;
                o_push.cmd.bytes[2] = r_end_byte;
                n_check_accum       = acc_close;
                n_frame_open        = 1'b0;
            end else begin
                // stray data or close, or unused code: dropped
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_accum     <= '0;
            r_payload_count   <= '0;
            r_declared_length <= '0;
            r_frame_open      <= 1'b0;
        end else begin
            r_check_accum     <= n_check_accum;
            r_payload_count   <= n_payload_count;
            r_declared_length <= n_declared_length;
            r_frame_open      <= n_frame_open;
        end
    end

endmodule

### rtl/lrc_fb_queue.sv
// command queue between front and back end
// depends on lrc_fb_pkg and the assertion macro header
module lrc_fb_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lrc_fb_pkg::t_q_push   i_push,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_head_valid,
    output lrc_fb_pkg::t_cmd      o_head
);
    import lrc_fb_pkg::*;

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;

    assign o_full       = (r_count == Q_DEPTH[Q_AW:0]);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`include "lrc_frame_builder_top_macros.svh"

    `LRC_ASSERT_NOW(a_count_range, 1'b1, r_count <= Q_DEPTH[Q_AW:0], "queue count beyond depth")
    `LRC_ASSERT_NOW(a_no_push_full, i_push.valid, !o_full || i_pop, "push into full queue")
    `LRC_ASSERT_NOW(a_no_pop_empty, i_pop, o_head_valid, "pop from empty queue")
    `LRC_ASSERT_NEXT(a_push_fills, i_push.valid && !i_pop, o_head_valid, "push left queue empty")

endmodule

### rtl/lrc_fb_back.sv
// back end: walks the head command byte by byte into the output register
// depends on lrc_fb_pkg
module lrc_fb_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_head_valid,
    input  lrc_fb_pkg::t_cmd      i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lrc_fb_pkg::t_out_word o_out_data
);
    import lrc_fb_pkg::*;

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out_word, n_out_word;
    logic [IDX_W-1:0] last_idx;
    logic             advance;
    logic             at_last;

    always_comb begin
        unique case (i_head.kind)
            CMD_OPEN:  last_idx = IDX_W'(CMD_BYTES - 1);
            CMD_CLOSE: last_idx = IDX_W'(2);
            default:   last_idx = '0;
        endcase
    end

    assign advance = !r_out_valid || i_out_ready;
    assign at_last = (r_idx == last_idx);
    assign o_pop   = advance && i_head_valid && at_last;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        if (advance) begin
            n_out_valid = i_head_valid;
            if (i_head_valid) begin
                n_out_word.out_byte        = i_head.bytes[r_idx];
                n_out_word.run_last        = at_last;
                n_out_word.frame_end       = at_last && (i_head.kind == CMD_CLOSE);
                n_out_word.length_mismatch = (i_head.kind == CMD_CLOSE) && i_head.mismatch;
                n_idx = at_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

endmodule

### rtl/lrc_frame_builder_top.sv
// frame builder top level: front end, command queue, back end
// depends on lrc_fb_pkg, lrc_fb_front, lrc_fb_queue, lrc_fb_back
// path: an accepted word is written into the queue, then the back end registers its first byte as the result word
// throughput: one input word per cycle; ready drops while the 4-deep queue is full
// output: one byte per cycle from the back end while i_out_ready is high; an open gives 9, a close 3, a data word 1
// reset: synchronous active low; clears queue, frame state and config registers to zero
module lrc_frame_builder_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  lrc_fb_pkg::t_in_word              i_in_data,
    // result words
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output lrc_fb_pkg::t_out_word             o_out_data,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lrc_fb_pkg::CFG_AW-1:0]     i_cfg_index,
    input  logic [lrc_fb_pkg::CFG_DW-1:0]     i_cfg_data
);
    import lrc_fb_pkg::*;

    t_q_push q_push;
    logic    q_full;
    logic    q_pop;
    logic    head_valid;
    t_cmd    head;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    // front end: holds registers and frame state, classifies each word
    lrc_fb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (q_push)
    );

    // short queue so a header burst does not stall input
    lrc_fb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // back end: serializes commands into the registered output word
    lrc_fb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

### test/testbench.sv
// self-checking testbench for lrc_frame_builder_top: word stream in, frame bytes out
// depends on lrc_fb_pkg and the frame builder rtl; predicts every output word in a class
`timescale 1ns / 100ps

module testbench;

    import lrc_fb_pkg::*;

    // keeps a copy of the builder's registers and frame state, predicts the bytes each
    // accepted word produces and checks the output stream against them in order
    class frame_checker;
        logic [15:0] start_word;
        logic [31:0] vehicle_id;
        logic        checksum_en;
        logic [7:0]  default_check;
        logic [7:0]  plain_type;
        logic [7:0]  end_marker;

        logic [7:0]  check_accum;
        logic [15:0] payload_count;
        logic [15:0] declared_length;
        logic        frame_open;

        t_out_word   expected_bytes[$];
        int unsigned faults;

        function new();
            start_word      = '0;
            vehicle_id      = '0;
            checksum_en     = 1'b0;
            default_check   = '0;
            plain_type      = '0;
            end_marker      = '0;
            check_accum     = '0;
            payload_count   = '0;
            declared_length = '0;
            frame_open      = 1'b0;
            faults          = 0;
        endfunction

        function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                REG_START_WORD:  start_word    = data[15:0];
                REG_VEHICLE_ID:  vehicle_id    = data[31:0];
                REG_CHECK_EN:    checksum_en   = data[0];
                REG_DEFAULT_CHK: default_check = data[7:0];
                REG_PLAIN_TYPE:  plain_type    = data[7:0];
                REG_END_BYTE:    end_marker    = data[7:0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] b, logic last, logic fend, logic mis);
            t_out_word r;
            r.out_byte        = b;
            r.run_last        = last;
            r.frame_end       = fend;
            r.length_mismatch = mis;
            expected_bytes.push_back(r);
        endfunction

        // returns how many bytes the word produces
        function int note_word(t_in_word w);
            logic [15:0] flen;
            logic [7:0]  hdr [0:8];
            logic        mis;
            logic [7:0]  chk;
            case (w.action)
                ACT_OPEN: begin
                    flen = w.payload_length + FRAME_OVERHEAD;
                    hdr = '{start_word[15:8], start_word[7:0], flen[7:0], flen[15:8],
                            vehicle_id[7:0], vehicle_id[15:8], vehicle_id[23:16],
                            vehicle_id[31:24], w.seq_num};
                    check_accum = hdr[4] ^ hdr[5] ^ hdr[6] ^ hdr[7] ^ hdr[8];
                    for (int i = 0; i < CMD_BYTES; i++)
                        push_byte(hdr[i], i == CMD_BYTES - 1, 1'b0, 1'b0);
                    payload_count   = '0;
                    declared_length = w.payload_length;
                    frame_open      = 1'b1;
                    return CMD_BYTES;
                end
                ACT_DATA: begin
                    if (!frame_open)
                        return 0;
                    check_accum ^= w.data_byte;
                    if (payload_count != 16'hFFFF)
                        payload_count++;
                    push_byte(w.data_byte, 1'b1, 1'b0, 1'b0);
                    return 1;
                end
                ACT_CLOSE: begin
                    if (!frame_open)
                        return 0;
                    mis = (payload_count != declared_length);
                    check_accum ^= plain_type;
                    chk = checksum_en ? check_accum : default_check;
                    push_byte(plain_type, 1'b0, 1'b0, mis);
                    push_byte(chk, 1'b0, 1'b0, mis);
                    push_byte(end_marker, 1'b1, 1'b1, mis);
                    frame_open = 1'b0;
                    return 3;
                end
                default: return 0;
            endcase
        endfunction

        function void check_byte(t_out_word got);
            t_out_word exp;
            if (expected_bytes.size() == 0) begin
                $error("unexpected output word: out_byte %02h", got.out_byte);
                faults++;
                return;
            end
            exp = expected_bytes.pop_front();
            if (got.out_byte !== exp.out_byte) begin
                $error("out_byte: expected %02h, actual %02h", exp.out_byte, got.out_byte);
                faults++;
            end
            if (got.run_last !== exp.run_last) begin
                $error("run_last: expected %0b, actual %0b", exp.run_last, got.run_last);
                faults++;
            end
            if (got.frame_end !== exp.frame_end) begin
                $error("frame_end: expected %0b, actual %0b", exp.frame_end, got.frame_end);
                faults++;
            end
            if (got.length_mismatch !== exp.length_mismatch) begin
                $error("length_mismatch: expected %0b, actual %0b",
                       exp.length_mismatch, got.length_mismatch);
                faults++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    // action code that the builder has no use for
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // register indexes past the last defined register
    localparam logic [CFG_AW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_AW-1:0] REG_SPARE_HI = 3'd7;

    // how a phase fills the registers
    localparam int FILL_ONES = 0;
    localparam int FILL_ZERO = 1;
    localparam int FILL_RAND = 2;

    // cycles to let pass after the last byte before touching registers or ending
    localparam int SETTLE_CYCLES = 16;

    // accepted words that produce bytes, per random phase
    localparam int WORDS_PER_PHASE = 70;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_word              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_word             o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_AW-1:0]     i_cfg_index;
    logic [CFG_DW-1:0]     i_cfg_data;

    frame_checker sb;

    // idle odds in percent, changed per phase
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    // accepted words that produced at least one byte
    int unsigned framed_words;

    lrc_frame_builder_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // output side: random back-pressure, and every word taken is checked in order
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_byte(o_out_data);
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // waits until every predicted byte has come out
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // one input word; called at a rising edge, returns at the edge that takes it.
    // valid stays high between back-to-back words and only drops for a gap or a hold
    task automatic send(t_in_word w);
        int unsigned gap;
        bit          hold;
        gap  = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        // now and then hold off until the output side has caught up
        hold = ($urandom_range(49) == 0);
        if (gap != 0 || hold) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            if (hold)
                wait_drained();
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        if (sb.note_word(w) != 0)
            framed_words++;
    endtask

    task automatic send_fields(logic [1:0] act, logic [15:0] plen, logic [7:0] seq,
                               logic [7:0] data);
        t_in_word w;
        w.action         = act;
        w.payload_length = plen;
        w.seq_num        = seq;
        w.data_byte      = data;
        send(w);
    endtask

    function automatic t_in_word random_word();
        t_in_word w;
        w.action         = 2'($urandom_range(3));
        w.payload_length = 16'($urandom_range(16'hFFFF));
        w.seq_num        = 8'($urandom_range(8'hFF));
        w.data_byte      = 8'($urandom_range(8'hFF));
        return w;
    endfunction

    // one register write; cfg valid stays high across a batch, caller drops it
    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // rewrites all registers; full 32-bit data so unused upper bits are exercised
    task automatic program_regs(int fill, bit cs_en, bit spare);
        logic [CFG_DW-1:0] v;
        for (int i = REG_START_WORD; i <= REG_END_BYTE; i++) begin
            case (fill)
                FILL_ONES: v = '1;
                FILL_ZERO: v = '0;
                default:   v = $urandom;
            endcase
            if (i == REG_CHECK_EN)
                v[0] = cs_en;
            write_reg(i[CFG_AW-1:0], v);
        end
        // writes to unmapped indexes must leave every register alone
        if (spare) begin
            write_reg(REG_SPARE_LO, $urandom);
            write_reg(REG_SPARE_HI, $urandom);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly well-formed frames with random content; some declare a wild length,
    // some carry too few or too many payload bytes, a few are never closed
    task automatic send_frame();
        t_in_word    w;
        int unsigned n_data;
        w        = random_word();
        w.action = ACT_OPEN;
        if ($urandom_range(7) == 0) begin
            n_data = $urandom_range(6);
        end else begin
            w.payload_length = 16'($urandom_range(10));
            n_data           = 32'(w.payload_length);
            if ($urandom_range(4) == 0)
                n_data = $urandom_range(12);
        end
        send(w);
        repeat (n_data) begin
            w        = random_word();
            w.action = ACT_DATA;
            send(w);
        end
        if ($urandom_range(15) != 0) begin
            w        = random_word();
            w.action = ACT_CLOSE;
            send(w);
        end
    endtask

    // random words until enough have produced bytes, then drain and settle
    task automatic random_phase(int unsigned idle_pct, int unsigned stall);
        int unsigned goal;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        goal          = framed_words + WORDS_PER_PHASE;
        while (framed_words < goal) begin
            if ($urandom_range(9) < 8)
                send_frame();
            else
                send(random_word());
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        sb            = new();
        framed_words  = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with registers still at their reset values
        // payload, close and the spare code with no frame open are all dropped
        send_fields(ACT_DATA, 16'h0000, 8'h00, 8'hA5);
        send_fields(ACT_CLOSE, 16'hFFFF, 8'hFF, 8'hFF);
        send_fields(ACT_SPARE, 16'h1234, 8'h56, 8'h78);
        // empty frame, lengths agree
        send_fields(ACT_OPEN, 16'h0000, 8'h00, 8'h00);
        send_fields(ACT_CLOSE, 16'h0000, 8'h00, 8'h00);
        // largest declared length: length field wraps to 7, two bytes sent
        send_fields(ACT_OPEN, 16'hFFFF, 8'hFF, 8'hFF);
        send_fields(ACT_DATA, 16'hFFFF, 8'hFF, 8'hFF);
        send_fields(ACT_DATA, 16'h0000, 8'h00, 8'h00);
        send_fields(ACT_CLOSE, 16'hFFFF, 8'hFF, 8'hFF);
        // largest legal length gives an all-ones length field, then the frame is
        // dropped by a second open
        send_fields(ACT_OPEN, 16'd65527, 8'h80, 8'h01);
        send_fields(ACT_OPEN, 16'd2, 8'h01, 8'h80);
        send_fields(ACT_DATA, 16'h0000, 8'h00, 8'h5A);
        send_fields(ACT_SPARE, 16'hFFFF, 8'hFF, 8'hFF);
        send_fields(ACT_DATA, 16'h0000, 8'h00, 8'hC3);
        send_fields(ACT_CLOSE, 16'h0000, 8'h00, 8'h00);
        // one more payload byte than declared still goes through
        send_fields(ACT_OPEN, 16'd1, 8'h7F, 8'h00);
        send_fields(ACT_DATA, 16'h0000, 8'h00, 8'hFF);
        send_fields(ACT_DATA, 16'h0000, 8'h00, 8'h01);
        send_fields(ACT_CLOSE, 16'h0000, 8'h00, 8'h00);
        // a close right after the frame ended is dropped
        send_fields(ACT_CLOSE, 16'h0000, 8'h00, 8'h00);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // all ones, no idling on either side
        program_regs(FILL_ONES, 1'b1, 1'b1);
        random_phase(0, 0);

        // random registers with checksums on, sender mostly idle
        program_regs(FILL_RAND, 1'b1, 1'b0);
        random_phase(66, 0);

        // all zero with checksums on, receiver mostly stalled
        program_regs(FILL_ZERO, 1'b1, 1'b0);
        random_phase(0, 66);

        // random registers with the default check byte, both sides idling
        program_regs(FILL_RAND, 1'b0, 1'b0);
        random_phase(30, 30);

        // fully random registers, back to full speed
        program_regs(FILL_RAND, 1'($urandom_range(1)), 1'b1);
        random_phase(0, 0);

        if (sb.faults == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
